// ===== rtl/core/sgpc_pkg.sv =====
// shared constants and types for the scatter-gather page coalescer
package sgpc_pkg;

  localparam int DEF_MAX_SEGMENTS = 32;
  localparam int DEF_PAGE_BITS    = 12;
  localparam int DEF_FRAME_BITS   = 36;

  // segment byte length, saturating
  localparam int              BYTES_W   = 20;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  // depth of the queues between the parts
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_NEW  = 2'd0,
    ACT_HEAD = 2'd1,
    ACT_TAIL = 2'd2,
    ACT_DROP = 2'd3
  } act_t;

  typedef enum logic {
    REC_ACTION = 1'b0,
    REC_LIST   = 1'b1
  } rec_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CHECK,
    BK_NEW,
    BK_EMIT,
    BK_LIST
  } back_state_t;

endpackage

// ===== rtl/core/sgpc_ram.sv =====
// generic single-write, single-read ram with registered read data
module sgpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/sgpc_fifo.sv =====
// small register queue with the head entry visible
module sgpc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = sgpc_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/core/sgpc_front.sv =====
// front end: takes pages, works out their end frame and whole-page flag, queues them
module sgpc_front #(
  parameter int PAGE_BITS  = sgpc_pkg::DEF_PAGE_BITS,
  parameter int FRAME_BITS = sgpc_pkg::DEF_FRAME_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [FRAME_BITS-1:0] page_frame,
  input  logic [PAGE_BITS:0]    page_length,
  input  logic                  last_page,
  output logic                  q_valid,
  input  logic                  q_pop,
  output logic [2*FRAME_BITS+PAGE_BITS+2:0] q_data
);

  import sgpc_pkg::*;

  localparam int ITEM_W = 2 * FRAME_BITS + PAGE_BITS + 3;

  logic [FRAME_BITS-1:0] cur_next;
  logic                  cur_full;
  logic [ITEM_W-1:0]     item;
  logic                  q_empty;

  // end frame wraps at the frame width
  assign cur_next = page_frame + FRAME_BITS'(page_length >> PAGE_BITS);
  assign cur_full = (page_length[PAGE_BITS-1:0] == '0);
  assign item     = {page_frame, page_length, last_page, cur_next, cur_full};

  sgpc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (item),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_data),
    .empty (q_empty)
  );

  assign q_valid = !q_empty;

endmodule

// ===== rtl/core/sgpc_back.sv =====
// back end: hint check, backward scan, table update and list output
module sgpc_back #(
  parameter int MAX_SEGMENTS = sgpc_pkg::DEF_MAX_SEGMENTS,
  parameter int PAGE_BITS    = sgpc_pkg::DEF_PAGE_BITS,
  parameter int FRAME_BITS   = sgpc_pkg::DEF_FRAME_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic clustering_enable,
  input  logic q_valid,
  output logic q_pop,
  input  logic [2*FRAME_BITS+PAGE_BITS+2:0] q_data,
  output logic out_push,
  input  logic out_full,
  output logic [FRAME_BITS+sgpc_pkg::BYTES_W+$clog2(MAX_SEGMENTS)
                +$clog2(MAX_SEGMENTS+1)+3:0] out_data
);

  import sgpc_pkg::*;

  localparam int IDX_W   = $clog2(MAX_SEGMENTS);
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int LEN_W   = PAGE_BITS + 1;
  localparam int ENTRY_W = FRAME_BITS + BYTES_W;
  localparam int REC_W   = FRAME_BITS + BYTES_W + IDX_W + CNT_W + 4;

  back_state_t st_r, st_nxt;

  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      hint_idx_r, hint_idx_nxt;
  logic                  hint_vld_r, hint_vld_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  last_r, last_nxt;
  logic [FRAME_BITS-1:0] cnext_r, cnext_nxt;
  logic                  cfull_r, cfull_nxt;
  logic [IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic                  is_hint_r, is_hint_nxt;
  logic [IDX_W-1:0]      lst_idx_r, lst_idx_nxt;
  logic [REC_W-1:0]      res_r, res_nxt;

  logic                  ram_we, ram_re;
  logic [IDX_W-1:0]      ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

  logic [FRAME_BITS-1:0] seg_frame, seg_next, new_frame;
  logic [BYTES_W-1:0]    seg_len, sat_len;
  logic [BYTES_W:0]      len_sum;
  logic                  seg_full, head_hit, tail_hit, hint_ok, lst_last;

  sgpc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SEGMENTS)
  ) u_seg_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign seg_frame = ram_rdata[ENTRY_W-1:BYTES_W];
  assign seg_len   = ram_rdata[BYTES_W-1:0];
  assign seg_next  = seg_frame + FRAME_BITS'(seg_len >> PAGE_BITS);
  assign seg_full  = (seg_len[PAGE_BITS-1:0] == '0);
  assign len_sum   = {1'b0, seg_len} + (BYTES_W + 1)'(len_r);
  assign sat_len   = len_sum[BYTES_W] ? BYTES_MAX : len_sum[BYTES_W-1:0];
  assign head_hit  = (seg_frame == cnext_r) && cfull_r;
  assign tail_hit  = (seg_next == frame_r) && seg_full;
  assign new_frame = head_hit ? frame_r : seg_frame;
  assign hint_ok   = hint_vld_r && (CNT_W'(hint_idx_r) < count_r);
  assign lst_last  = (CNT_W'(lst_idx_r) == count_r - CNT_W'(1));

  always_comb begin
    st_nxt       = st_r;
    count_nxt    = count_r;
    hint_idx_nxt = hint_idx_r;
    hint_vld_nxt = hint_vld_r;
    frame_nxt    = frame_r;
    len_nxt      = len_r;
    last_nxt     = last_r;
    cnext_nxt    = cnext_r;
    cfull_nxt    = cfull_r;
    chk_idx_nxt  = chk_idx_r;
    is_hint_nxt  = is_hint_r;
    lst_idx_nxt  = lst_idx_r;
    res_nxt      = res_r;
    q_pop        = 1'b0;
    out_push     = 1'b0;
    out_data     = res_r;
    ram_we       = 1'b0;
    ram_waddr    = chk_idx_r;
    ram_wdata    = {new_frame, sat_len};
    ram_re       = 1'b0;
    ram_raddr    = hint_idx_r;

    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          {frame_nxt, len_nxt, last_nxt, cnext_nxt, cfull_nxt} = q_data;
          if (clustering_enable && hint_ok) begin
            ram_re      = 1'b1;
            ram_raddr   = hint_idx_r;
            chk_idx_nxt = hint_idx_r;
            is_hint_nxt = 1'b1;
            st_nxt      = BK_CHECK;
          end else if (clustering_enable && count_r != '0) begin
            ram_re      = 1'b1;
            ram_raddr   = IDX_W'(count_r - CNT_W'(1));
            chk_idx_nxt = IDX_W'(count_r - CNT_W'(1));
            is_hint_nxt = 1'b0;
            st_nxt      = BK_CHECK;
          end else begin
            st_nxt = BK_NEW;
          end
        end
      end

      BK_CHECK: begin
        if (head_hit || tail_hit) begin
          ram_we       = 1'b1;
          res_nxt      = {REC_ACTION, (head_hit ? ACT_HEAD : ACT_TAIL), chk_idx_r,
                          new_frame, sat_len, count_r, !last_r};
          hint_idx_nxt = chk_idx_r;
          hint_vld_nxt = 1'b1;
          st_nxt       = BK_EMIT;
        end else if (is_hint_r) begin
          // hint missed: full scan from the newest entry
          ram_re      = 1'b1;
          ram_raddr   = IDX_W'(count_r - CNT_W'(1));
          chk_idx_nxt = IDX_W'(count_r - CNT_W'(1));
          is_hint_nxt = 1'b0;
        end else if (chk_idx_r == '0) begin
          st_nxt = BK_NEW;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = chk_idx_r - IDX_W'(1);
          chk_idx_nxt = chk_idx_r - IDX_W'(1);
        end
      end

      BK_NEW: begin
        hint_vld_nxt = 1'b0;
        if (count_r < CNT_W'(MAX_SEGMENTS)) begin
          ram_we    = 1'b1;
          ram_waddr = IDX_W'(count_r);
          ram_wdata = {frame_r, BYTES_W'(len_r)};
          count_nxt = count_r + CNT_W'(1);
          res_nxt   = {REC_ACTION, ACT_NEW, IDX_W'(count_r), frame_r, BYTES_W'(len_r),
                       count_r + CNT_W'(1), !last_r};
        end else begin
          res_nxt = {REC_ACTION, ACT_DROP, {IDX_W{1'b0}}, {FRAME_BITS{1'b0}},
                     {BYTES_W{1'b0}}, count_r, (!last_r || count_r == '0)};
        end
        st_nxt = BK_EMIT;
      end

      BK_EMIT: begin
        out_push = !out_full;
        out_data = res_r;
        if (!out_full) begin
          if (!last_r) begin
            st_nxt = BK_IDLE;
          end else if (count_r != '0) begin
            ram_re      = 1'b1;
            ram_raddr   = '0;
            lst_idx_nxt = '0;
            st_nxt      = BK_LIST;
          end else begin
            hint_idx_nxt = '0;
            hint_vld_nxt = 1'b0;
            st_nxt       = BK_IDLE;
          end
        end
      end

      BK_LIST: begin
        out_push = !out_full;
        out_data = {REC_LIST, ACT_NEW, lst_idx_r, seg_frame, seg_len, count_r, lst_last};
        if (!out_full) begin
          if (lst_last) begin
            count_nxt    = '0;
            hint_idx_nxt = '0;
            hint_vld_nxt = 1'b0;
            st_nxt       = BK_IDLE;
          end else begin
            ram_re      = 1'b1;
            ram_raddr   = lst_idx_r + IDX_W'(1);
            lst_idx_nxt = lst_idx_r + IDX_W'(1);
          end
        end
      end

      default: begin
        st_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= BK_IDLE;
      count_r    <= '0;
      hint_idx_r <= '0;
      hint_vld_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      count_r    <= count_nxt;
      hint_idx_r <= hint_idx_nxt;
      hint_vld_r <= hint_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frame_r   <= frame_nxt;
    len_r     <= len_nxt;
    last_r    <= last_nxt;
    cnext_r   <= cnext_nxt;
    cfull_r   <= cfull_nxt;
    chk_idx_r <= chk_idx_nxt;
    is_hint_r <= is_hint_nxt;
    lst_idx_r <= lst_idx_nxt;
    res_r     <= res_nxt;
  end

endmodule

// ===== rtl/core/scatter_gather_page_coalescer.sv =====
// top level: page queue, merge engine and result queue of the page coalescer
// flow: a page enters the page queue, then the engine checks the hint entry, scans the table
//   backward from the newest entry, then merges, adds or drops the page, into the result queue
// pages go one at a time: the engine pops the next only after the last result is queued; scans
//   are set by the single read port of the segment ram; listing one per cycle unless stalled
// reset: synchronous rst_n empties both queues, clears count and hint, sets clustering on
module scatter_gather_page_coalescer #(
  parameter int MAX_SEGMENTS = sgpc_pkg::DEF_MAX_SEGMENTS,
  parameter int PAGE_BITS    = sgpc_pkg::DEF_PAGE_BITS,
  parameter int FRAME_BITS   = sgpc_pkg::DEF_FRAME_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic                              cfg_wdata,
  // page transactions in
  input  logic                              push,
  output logic                              full,
  input  logic [FRAME_BITS-1:0]             in_page_frame,
  input  logic [PAGE_BITS:0]                in_page_length,
  input  logic                              in_last_page,
  // result transactions out
  output logic                              empty,
  input  logic                              pop,
  output logic                              out_record_type,
  output logic [1:0]                        out_action,
  output logic [$clog2(MAX_SEGMENTS)-1:0]   out_segment_index,
  output logic [FRAME_BITS-1:0]             out_segment_frame,
  output logic [sgpc_pkg::BYTES_W-1:0]      out_segment_bytes,
  output logic [$clog2(MAX_SEGMENTS+1)-1:0] out_segment_count,
  output logic                              out_last_result
);

  import sgpc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_SEGMENTS);
  localparam int CNT_W  = $clog2(MAX_SEGMENTS + 1);
  localparam int ITEM_W = 2 * FRAME_BITS + PAGE_BITS + 3;
  localparam int REC_W  = FRAME_BITS + BYTES_W + IDX_W + CNT_W + 4;

  // clustering enable; the user writes it only while the block is idle (not enforced here)
  logic clust_en_r, clust_en_nxt;

  assign clust_en_nxt = cfg_we ? cfg_wdata : clust_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clust_en_r <= 1'b1;
    end else begin
      clust_en_r <= clust_en_nxt;
    end
  end

  // page queue between the front end and the merge engine
  logic              q_valid, q_pop;
  logic [ITEM_W-1:0] q_data;

  sgpc_front #(
    .PAGE_BITS  (PAGE_BITS),
    .FRAME_BITS (FRAME_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .page_frame  (in_page_frame),
    .page_length (in_page_length),
    .last_page   (in_last_page),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_data      (q_data)
  );

  // merge engine: hint check, newest-to-oldest scan, table write, listing
  logic             res_push, res_full;
  logic [REC_W-1:0] res_data, head_data;

  sgpc_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .PAGE_BITS    (PAGE_BITS),
    .FRAME_BITS   (FRAME_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .clustering_enable (clust_en_r),
    .q_valid           (q_valid),
    .q_pop             (q_pop),
    .q_data            (q_data),
    .out_push          (res_push),
    .out_full          (res_full),
    .out_data          (res_data)
  );

  // result queue lets the engine run on while the consumer stalls, until the queue is full
  sgpc_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (head_data),
    .empty (empty)
  );

  assign {out_record_type, out_action, out_segment_index, out_segment_frame,
          out_segment_bytes, out_segment_count, out_last_result} = head_data;

  // the list never holds more segments than the table
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> out_segment_count <= CNT_W'(MAX_SEGMENTS))
    else $error("segment count above table size");

  // listing transactions carry no page action
  a_list_action: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_record_type == REC_LIST) |-> out_action == ACT_NEW)
    else $error("listing record with an action code");

  // a dropped page only happens with a full table and reports no segment
  a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_action == ACT_DROP) |->
      (out_segment_count == CNT_W'(MAX_SEGMENTS) && out_segment_bytes == '0 &&
       out_segment_frame == '0))
    else $error("dropped page with segment data");

  // queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> (!full && empty))
    else $error("queue not empty after reset");

endmodule
